>>> sv/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_CLK(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// clocked assertion that is checked during reset too
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> sv/sha5_pkg.sv
// package: request and digest types, controller codes, sha-512 constants and functions
`timescale 1ns / 1ps
package sha5_pkg;

	localparam int unsigned NumRounds = 80;
	localparam int unsigned BlockBytes = 128;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned LenOffset = 112;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [2:0]  word_index;
		logic [63:0] digest_word;
		logic        last;
		logic        length_overflow;
	} rsp_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_DATA,
		PH_EXTRA,
		PH_LAST
	} phase_t;

	typedef struct packed {
		logic       absorb;
		logic       pad;
		logic       zero_len;
		logic       init;
		logic       round;
		logic       final_add;
		logic       clear;
		logic [6:0] rnd;
		logic [2:0] emit_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic len_ovf;
		logic pad_extra;
	} dp_sts_t;

	localparam logic [63:0] IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
		64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	localparam logic [63:0] KTAB [80] = '{
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
	};

	function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] sig0(input logic [63:0] x);
		sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [63:0] sig1(input logic [63:0] x);
		sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic logic [63:0] bsig0(input logic [63:0] x);
		bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic logic [63:0] bsig1(input logic [63:0] x);
		bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

endpackage

>>> sv/sha5_datapath.sv
// datapath: block buffer and schedule window, working variables, hash words, length counter
`timescale 1ns / 1ps
module sha5_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  sha5_pkg::dp_cmd_t cmd,
	input  logic [7:0]      data_byte,
	output sha5_pkg::dp_sts_t sts,
	output logic [63:0]     digest_word,
	output logic            length_overflow
);
	import sha5_pkg::*;

	logic [63:0] h_q [8];
	logic [63:0] wv_q [BlockWords];
	logic [63:0] wv_d [BlockWords];
	logic [63:0] st_q [8];
	logic [6:0]  fill_q;
	logic [63:0] len_hi_q;
	logic [63:0] len_lo_q;
	logic        ovf_q;
	logic        len_ovf;
	logic [63:0] w_new;
	logic [63:0] t1;
	logic [63:0] t2;
	logic [63:0] ch;
	logic [63:0] maj;
	logic [127:0] len_sum;

	assign len_ovf = (&len_hi_q) && (&len_lo_q[63:3]);
	assign sts.fill_last = (&fill_q);
	assign sts.len_ovf = len_ovf;
	assign sts.pad_extra = (fill_q >= 7'(LenOffset));
	assign digest_word = h_q[cmd.emit_idx];
	assign length_overflow = ovf_q;
	assign len_sum = {len_hi_q, len_lo_q} + 128'd8;

	assign w_new = sig1(wv_q[14]) + wv_q[9] + sig0(wv_q[1]) + wv_q[0];
	assign ch = (st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]);
	assign maj = (st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]);
	assign t1 = st_q[7] + bsig1(st_q[4]) + ch + KTAB[cmd.rnd] + wv_q[0];
	assign t2 = bsig0(st_q[0]) + maj;

	always_comb begin
		wv_d = wv_q;
		if (cmd.absorb) begin
			wv_d[fill_q[6:3]][{~fill_q[2:0], 3'b000} +: 8] = data_byte;
		end
		if (cmd.pad) begin
			for (int b = 0; b < BlockBytes; b++) begin
				if (7'(b) > fill_q) begin
					wv_d[b / 8][(7 - (b % 8)) * 8 +: 8] = 8'h00;
				end
			end
			wv_d[fill_q[6:3]][{~fill_q[2:0], 3'b000} +: 8] = 8'h80;
			if (fill_q < 7'(LenOffset)) begin
				wv_d[14] = len_hi_q;
				wv_d[15] = len_lo_q;
			end
		end
		if (cmd.zero_len) begin
			for (int w = 0; w < 14; w++) begin
				wv_d[w] = '0;
			end
			wv_d[14] = len_hi_q;
			wv_d[15] = len_lo_q;
		end
		if (cmd.round) begin
			for (int w = 0; w < BlockWords - 1; w++) begin
				wv_d[w] = wv_q[w + 1];
			end
			wv_d[BlockWords - 1] = w_new;
		end
	end

	always_ff @(posedge clk) begin
		wv_q <= wv_d;
		if (cmd.init) begin
			st_q <= h_q;
		end else if (cmd.round) begin
			st_q[7] <= st_q[6];
			st_q[6] <= st_q[5];
			st_q[5] <= st_q[4];
			st_q[4] <= st_q[3] + t1;
			st_q[3] <= st_q[2];
			st_q[2] <= st_q[1];
			st_q[1] <= st_q[0];
			st_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= IV;
			fill_q <= '0;
			len_hi_q <= '0;
			len_lo_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			h_q <= IV;
			fill_q <= '0;
			len_hi_q <= '0;
			len_lo_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.absorb) begin
				if (len_ovf) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + 7'd1;
					len_hi_q <= len_sum[127:64];
					len_lo_q <= len_sum[63:0];
				end
			end
			if (cmd.final_add) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + st_q[i];
				end
			end
		end
	end

endmodule

>>> sv/sha5_ctrl.sv
// controller: request intake, compression sequencing and digest emission
`timescale 1ns / 1ps
module sha5_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sha5_pkg::req_t    req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              rsp_last,
	output sha5_pkg::dp_cmd_t cmd,
	input  sha5_pkg::dp_sts_t sts
);
	import sha5_pkg::*;

	state_t     state_q;
	state_t     state_d;
	phase_t     phase_q;
	logic [6:0] rnd_q;
	logic [2:0] emit_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc = req_valid && !req_stall;
	assign rsp_valid = (state_q == ST_EMIT);
	assign rsp_acc = rsp_valid && !rsp_stall;
	assign rsp_last = (&emit_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					if (req_data.opcode == OP_FINISH) begin
						state_d = ST_INIT;
					end else if (sts.fill_last && !sts.len_ovf) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: state_d = ST_ROUND;
			ST_ROUND: begin
				if (rnd_q == 7'(NumRounds - 1)) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				unique case (phase_q)
					PH_DATA:  state_d = ST_IDLE;
					PH_EXTRA: state_d = ST_INIT;
					PH_LAST:  state_d = ST_EMIT;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_EMIT: begin
				if (rsp_acc && rsp_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.emit_idx = emit_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.absorb = req_acc && (req_data.opcode == OP_ABSORB);
				cmd.pad = req_acc && (req_data.opcode == OP_FINISH);
			end
			ST_INIT:  cmd.init = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_FINAL: begin
				cmd.final_add = 1'b1;
				cmd.zero_len = (phase_q == PH_EXTRA);
			end
			ST_EMIT:  cmd.clear = rsp_acc && rsp_last;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_DATA;
			rnd_q <= '0;
			emit_q <= '0;
		end else begin
			state_q <= state_d;
			if (req_acc) begin
				if (req_data.opcode == OP_FINISH) begin
					phase_q <= sts.pad_extra ? PH_EXTRA : PH_LAST;
				end else begin
					phase_q <= PH_DATA;
				end
			end else if (state_q == ST_FINAL && phase_q == PH_EXTRA) begin
				phase_q <= PH_LAST;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 7'd1;
			end else begin
				rnd_q <= '0;
			end
			if (rsp_acc) begin
				emit_q <= emit_q + 3'd1;
			end
		end
	end

endmodule

>>> sv/sha512_hash_engine.sv
// SHA-512 engine taking one message byte per request; a finish request pads the
// message, runs the closing compression and returns the eight digest words in
// order. The byte that completes a 128-byte block starts a compression (load, 80
// rounds on the single round unit, chaining add) during which requests stall. A
// finish runs the same compression, twice when the length needs an extra block,
// and then emits the eight digest words. The length_overflow flag is reported
// on every digest word and cleared with the rest of the state after the last one.
`timescale 1ns / 1ps
module sha512_hash_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  sha5_pkg::req_t   req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output sha5_pkg::rsp_t   rsp_data
);
	import sha5_pkg::*;

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic        rsp_last;
	logic [63:0] digest_word;
	logic        length_overflow;

	sha5_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_last  (rsp_last),
		.cmd       (cmd),
		.sts       (sts)
	);

	sha5_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.data_byte       (req_data.data_byte),
		.sts             (sts),
		.digest_word     (digest_word),
		.length_overflow (length_overflow)
	);

	assign rsp_data.word_index = cmd.emit_idx;
	assign rsp_data.digest_word = digest_word;
	assign rsp_data.last = rsp_last;
	assign rsp_data.length_overflow = length_overflow;

endmodule

>>> sv/sha5_chk.sv
// port checker for the sha-512 engine and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha5_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input sha5_pkg::req_t req_data,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input sha5_pkg::rsp_t rsp_data
);
	import sha5_pkg::*;

	`ASSERT_CLK(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled digest word changed")
	`ASSERT_CLK(a_word_seq, clk, arst_n, rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid && rsp_data.word_index == 3'($past(rsp_data.word_index) + 3'd1), "digest words out of sequence")
	`ASSERT_CLK(a_last_idx, clk, arst_n, rsp_valid |-> rsp_data.last == (&rsp_data.word_index), "last flag not on final word")
	`ASSERT_CLK(a_busy_emit, clk, arst_n, rsp_valid |-> req_stall, "request taken while digest pending")
	`ASSERT_CLK(a_first_word, clk, arst_n, $rose(rsp_valid) |-> rsp_data.word_index == 3'd0, "digest does not start at word zero")

endmodule

bind sha512_hash_engine sha5_chk u_chk (.*);

>>> sim/tb_top.sv
// testbench for the sha-512 hash engine: byte requests checked against a local digest model
`timescale 1ns / 1ps
module tb_top;
	import sha5_pkg::req_t;
	import sha5_pkg::rsp_t;
	import sha5_pkg::OP_ABSORB;
	import sha5_pkg::OP_FINISH;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 500;

	localparam logic [63:0] H_INIT [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
		64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	localparam logic [63:0] RK [80] = '{
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	sha512_hash_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	// digest model state
	logic [63:0] hv [8];
	logic [7:0] msg_blk [128];
	int unsigned blk_fill;
	logic [63:0] nbits_lo;
	logic [63:0] nbits_hi;
	logic ovf_flag;

	rsp_t digest_q [$];
	int send_idle_pct;
	int recv_stall_pct;
	int req_count;
	int msg_count;
	int word_count;
	int mismatches;
	int idle_cycles;
	int hold_left;
	logic hold_go;
	logic hold_seen;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic void digest_reset();
		for (int i = 0; i < 8; i++) hv[i] = H_INIT[i];
		for (int i = 0; i < 128; i++) msg_blk[i] = 8'h00;
		blk_fill = 0;
		nbits_lo = '0;
		nbits_hi = '0;
		ovf_flag = 1'b0;
	endfunction

	function automatic void digest_block();
		logic [63:0] w [80];
		logic [63:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) begin
			w[i] = '0;
			for (int j = 0; j < 8; j++) w[i] = (w[i] << 8) | 64'(msg_blk[i * 8 + j]);
		end
		for (int i = 16; i < 80; i++) begin
			s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
			s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
		e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
		for (int i = 0; i < 80; i++) begin
			t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
				+ RK[i] + w[i];
			t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
		hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
	endfunction

	function automatic void digest_step(input req_t r);
		int unsigned pos;
		rsp_t x;
		if (r.opcode == OP_ABSORB) begin
			if (nbits_hi == '1 && nbits_lo > 64'hFFFF_FFFF_FFFF_FFF7) begin
				ovf_flag = 1'b1;
				return;
			end
			nbits_lo += 64'd8;
			if (nbits_lo < 64'd8) nbits_hi += 64'd1;
			msg_blk[blk_fill] = r.data_byte;
			blk_fill++;
			if (blk_fill == 128) begin
				digest_block();
				blk_fill = 0;
			end
			return;
		end
		pos = blk_fill;
		msg_blk[pos] = 8'h80;
		pos++;
		if (pos > 112) begin
			for (int i = pos; i < 128; i++) msg_blk[i] = 8'h00;
			digest_block();
			pos = 0;
		end
		for (int i = pos; i < 112; i++) msg_blk[i] = 8'h00;
		for (int i = 0; i < 8; i++) begin
			msg_blk[112 + i] = nbits_hi[63 - 8 * i -: 8];
			msg_blk[120 + i] = nbits_lo[63 - 8 * i -: 8];
		end
		digest_block();
		for (int i = 0; i < 8; i++) begin
			x.word_index = 3'(i);
			x.digest_word = hv[i];
			x.last = (i == 7);
			x.length_overflow = ovf_flag;
			digest_q.push_back(x);
		end
		digest_reset();
	endfunction

	task automatic send_req(input logic op, input logic [7:0] byte_val);
		req_t r;
		r.opcode = op;
		r.data_byte = byte_val;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		digest_step(r);
		req_count++;
		if (op == OP_FINISH) msg_count++;
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) send_req(OP_ABSORB, 8'($urandom));
		send_req(OP_FINISH, 8'($urandom));
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_message();
		send_req(OP_FINISH, 8'h00);
	endtask

	task automatic test_byte_extremes();
		send_req(OP_ABSORB, 8'h00);
		send_req(OP_ABSORB, 8'hFF);
		send_req(OP_FINISH, 8'hFF);
		send_req(OP_ABSORB, 8'hFF);
		send_req(OP_FINISH, 8'h00);
		send_req(OP_ABSORB, 8'h61);
		send_req(OP_ABSORB, 8'h62);
		send_req(OP_ABSORB, 8'h63);
		send_req(OP_FINISH, 8'hA5);
		drain();
	endtask

	// lengths clustered around the padding and block boundaries
	task automatic test_random_messages(input int sidle, input int rstall, input int target);
		int len;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		while (req_count < target) begin
			case ($urandom_range(5))
				0: len = $urandom_range(0, 4);
				1: len = $urandom_range(108, 116);
				2: len = $urandom_range(124, 132);
				3: len = $urandom_range(236, 260);
				default: len = $urandom_range(5, 40);
			endcase
			send_message(len);
		end
		drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_go <= ~hold_go;
		for (int m = 0; m < 4; m++) send_message($urandom_range(0, 3));
		drain();
	endtask

	// result checker and receiver stall
	always @(posedge clk or negedge arst_n) begin
		rsp_t x;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				word_count++;
				if (digest_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected digest word %p", rsp_data);
				end else begin
					x = digest_q.pop_front();
					if (rsp_data.word_index !== x.word_index
						|| rsp_data.digest_word !== x.digest_word
						|| rsp_data.last !== x.last
						|| rsp_data.length_overflow !== x.length_overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d %h %b %b, got %0d %h %b %b",
								x.word_index, x.digest_word, x.last, x.length_overflow,
								rsp_data.word_index, rsp_data.digest_word, rsp_data.last,
								rsp_data.length_overflow);
					end
				end
			end
			if (hold_go != hold_seen) begin
				hold_seen <= hold_go;
				hold_left <= HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		hold_go <= 1'b0;
		idle_cycles = 0;
		req_count = 0;
		msg_count = 0;
		word_count = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		digest_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_message();
		test_byte_extremes();
		test_random_messages(11, 74, 130);
		test_random_messages(74, 11, 240);
		test_backpressure();
		test_random_messages(0, 0, 350);
		repeat (200) @(posedge clk);
		$display("covered %0d requests in %0d messages, %0d digest words checked",
			req_count, msg_count, word_count);
		$display("lengths near padding and block boundaries, empty message, long output hold");
		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d words missing", mismatches, digest_q.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/sha5_pkg.sv
sv/sha5_datapath.sv
sv/sha5_ctrl.sv
sv/sha512_hash_engine.sv
sv/sha5_chk.sv
sim/tb_top.sv
